>>> src/ann_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ann_pkg;

    localparam int OP_W   = 4;
    localparam int DUR_W  = 16;
    localparam int LED_TW = 11;
    localparam int CNT_W  = 2;

    localparam logic [OP_W-1:0] OP_TICK     = 4'd0;
    localparam logic [OP_W-1:0] OP_READ_OK  = 4'd1;
    localparam logic [OP_W-1:0] OP_WRITE_OK = 4'd2;
    localparam logic [OP_W-1:0] OP_FAIL     = 4'd3;
    localparam logic [OP_W-1:0] OP_TAG      = 4'd4;
    localparam logic [OP_W-1:0] OP_SAVED    = 4'd5;
    localparam logic [OP_W-1:0] OP_DB_OK    = 4'd6;
    localparam logic [OP_W-1:0] OP_DB_FAIL  = 4'd7;
    localparam logic [OP_W-1:0] OP_BEEP     = 4'd8;
    localparam logic [OP_W-1:0] OP_GREEN    = 4'd9;
    localparam logic [OP_W-1:0] OP_RED      = 4'd10;
    localparam logic [OP_W-1:0] OP_ALL_OFF  = 4'd11;

    // beep times in ms
    localparam logic [DUR_W-1:0] T_SHORT_BEEP = 16'd100;
    localparam logic [DUR_W-1:0] T_LONG_BEEP  = 16'd500;
    localparam logic [DUR_W-1:0] T_CLICK      = 16'd50;
    localparam logic [DUR_W-1:0] T_GAP        = 16'd100;

    // LED timeouts in ms
    localparam logic [LED_TW-1:0] T_GREEN_READ  = 11'd1000;
    localparam logic [LED_TW-1:0] T_GREEN_WRITE = 11'd1500;
    localparam logic [LED_TW-1:0] T_RED_FAIL    = 11'd2000;
    localparam logic [LED_TW-1:0] T_GREEN_TAG   = 11'd200;
    localparam logic [LED_TW-1:0] T_GREEN_SAVED = 11'd500;

    // register indexes
    localparam logic REG_BEEP_ENABLE = 1'b0;
    localparam logic REG_BLOCK_READY = 1'b1;

    typedef struct packed {
        logic beep_enable;
        logic block_ready;
    } t_cfg;

    typedef struct packed {
        logic buzzer;
        logic green;
        logic red;
    } t_levels;

endpackage

`default_nettype wire

>>> src/ann_regs.sv
`timescale 1ns / 1ps
`default_nettype none

module ann_regs
    import ann_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output      logic [31:0] prdata,
    output      logic        pready,
    output      t_cfg        o_cfg
);

    logic r_beep_enable;
    logic r_block_ready;
    logic wr_en;
    logic reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beep_enable <= 1'b1;
            r_block_ready <= 1'b0;
        end else if (wr_en) begin
            if (reg_idx == REG_BEEP_ENABLE) begin
                r_beep_enable <= pwdata[0];
            end else begin
                r_block_ready <= pwdata[0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_BEEP_ENABLE) begin
            prdata[0] = r_beep_enable;
        end else begin
            prdata[0] = r_block_ready;
        end
    end

    assign o_cfg.beep_enable = r_beep_enable;
    assign o_cfg.block_ready = r_block_ready;

endmodule

`default_nettype wire

>>> src/ann_core.sv
`timescale 1ns / 1ps
`default_nettype none

module ann_core
    import ann_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_cfg             i_cfg,
    input  wire logic             i_fire,
    input  wire logic [OP_W-1:0]  i_op,
    input  wire logic [DUR_W-1:0] i_dur,
    input  wire logic             i_lvl,
    output      t_levels          o_levels
);

    logic [CNT_W-1:0]  r_beeps_left,  n_beeps_left;
    logic              r_phase_on,    n_phase_on;
    logic [DUR_W-1:0]  r_phase_rem,   n_phase_rem;
    logic [DUR_W-1:0]  r_on_time,     n_on_time;
    logic [DUR_W-1:0]  r_off_time,    n_off_time;
    logic              r_buzzer,      n_buzzer;
    logic              r_green,       n_green;
    logic              r_red,         n_red;
    logic [LED_TW-1:0] r_green_rem,   n_green_rem;
    logic              r_green_armed, n_green_armed;
    logic [LED_TW-1:0] r_red_rem,     n_red_rem;
    logic              r_red_armed,   n_red_armed;

    always_comb begin
        logic             pat_go;
        logic [CNT_W-1:0] pat_cnt;
        logic [DUR_W-1:0] pat_on;
        logic [DUR_W-1:0] pat_off;
        logic [DUR_W-1:0] dec_phase;
        logic [CNT_W-1:0] dec_beeps;

        n_beeps_left  = r_beeps_left;
        n_phase_on    = r_phase_on;
        n_phase_rem   = r_phase_rem;
        n_on_time     = r_on_time;
        n_off_time    = r_off_time;
        n_buzzer      = r_buzzer;
        n_green       = r_green;
        n_red         = r_red;
        n_green_rem   = r_green_rem;
        n_green_armed = r_green_armed;
        n_red_rem     = r_red_rem;
        n_red_armed   = r_red_armed;

        pat_go    = 1'b0;
        pat_cnt   = 2'd1;
        pat_on    = T_SHORT_BEEP;
        pat_off   = '0;
        dec_phase = (r_phase_rem != '0) ? r_phase_rem - 1'b1 : '0;
        dec_beeps = r_beeps_left - 1'b1;

        case (i_op)
            OP_TICK: begin
                if (i_cfg.block_ready) begin
                    if (r_beeps_left != '0) begin
                        n_phase_rem = dec_phase;
                        if (dec_phase == '0) begin
                            if (r_phase_on) begin
                                n_buzzer     = 1'b0;
                                n_phase_on   = 1'b0;
                                n_beeps_left = dec_beeps;
                                if (dec_beeps != '0) begin
                                    n_phase_rem = r_off_time;
                                end
                            end else begin
                                n_buzzer    = 1'b1;
                                n_phase_on  = 1'b1;
                                n_phase_rem = r_on_time;
                            end
                        end
                    end
                    if (r_green_armed) begin
                        if (r_green_rem != '0) begin
                            n_green_rem = r_green_rem - 1'b1;
                        end
                        if (r_green && n_green_rem == '0) begin
                            n_green       = 1'b0;
                            n_green_armed = 1'b0;
                        end
                    end
                    if (r_red_armed) begin
                        if (r_red_rem != '0) begin
                            n_red_rem = r_red_rem - 1'b1;
                        end
                        if (r_red && n_red_rem == '0) begin
                            n_red       = 1'b0;
                            n_red_armed = 1'b0;
                        end
                    end
                end
            end
            OP_READ_OK: begin
                pat_go        = 1'b1;
                n_green       = 1'b1;
                n_green_rem   = T_GREEN_READ;
                n_green_armed = 1'b1;
            end
            OP_WRITE_OK: begin
                pat_go        = 1'b1;
                pat_cnt       = 2'd2;
                pat_off       = T_GAP;
                n_green       = 1'b1;
                n_green_rem   = T_GREEN_WRITE;
                n_green_armed = 1'b1;
            end
            OP_FAIL, OP_DB_FAIL: begin
                pat_go      = 1'b1;
                pat_on      = T_LONG_BEEP;
                n_red       = 1'b1;
                n_red_rem   = T_RED_FAIL;
                n_red_armed = 1'b1;
            end
            OP_TAG: begin
                pat_go        = 1'b1;
                pat_on        = T_CLICK;
                n_green       = 1'b1;
                n_green_rem   = T_GREEN_TAG;
                n_green_armed = 1'b1;
            end
            OP_SAVED: begin
                pat_go        = 1'b1;
                n_green       = 1'b1;
                n_green_rem   = T_GREEN_SAVED;
                n_green_armed = 1'b1;
            end
            OP_DB_OK: begin
                pat_go        = 1'b1;
                pat_cnt       = 2'd2;
                pat_off       = T_GAP;
                n_green       = 1'b1;
                n_green_rem   = T_GREEN_READ;
                n_green_armed = 1'b1;
            end
            OP_BEEP: begin
                pat_go = 1'b1;
                pat_on = i_dur;
            end
            OP_GREEN: begin
                n_green = i_lvl;
            end
            OP_RED: begin
                n_red = i_lvl;
            end
            OP_ALL_OFF: begin
                n_buzzer      = 1'b0;
                n_green       = 1'b0;
                n_red         = 1'b0;
                n_beeps_left  = '0;
                n_green_armed = 1'b0;
                n_red_armed   = 1'b0;
            end
            default: begin
            end
        endcase

        // pattern start aborts whatever pattern is running
        if (pat_go && i_cfg.beep_enable && i_cfg.block_ready) begin
            n_beeps_left = pat_cnt;
            n_on_time    = pat_on;
            n_off_time   = pat_off;
            n_buzzer     = 1'b1;
            n_phase_on   = 1'b1;
            n_phase_rem  = pat_on;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beeps_left  <= '0;
            r_phase_on    <= 1'b0;
            r_phase_rem   <= '0;
            r_on_time     <= '0;
            r_off_time    <= '0;
            r_buzzer      <= 1'b0;
            r_green       <= 1'b0;
            r_red         <= 1'b0;
            r_green_rem   <= '0;
            r_green_armed <= 1'b0;
            r_red_rem     <= '0;
            r_red_armed   <= 1'b0;
        end else if (i_fire) begin
            r_beeps_left  <= n_beeps_left;
            r_phase_on    <= n_phase_on;
            r_phase_rem   <= n_phase_rem;
            r_on_time     <= n_on_time;
            r_off_time    <= n_off_time;
            r_buzzer      <= n_buzzer;
            r_green       <= n_green;
            r_red         <= n_red;
            r_green_rem   <= n_green_rem;
            r_green_armed <= n_green_armed;
            r_red_rem     <= n_red_rem;
            r_red_armed   <= n_red_armed;
        end
    end

    assign o_levels.buzzer = r_buzzer;
    assign o_levels.green  = r_green;
    assign o_levels.red    = r_red;

    // buzzer only sounds inside a pattern
    a_buzz_in_pattern: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_buzzer |-> r_beeps_left != '0)
        else $error("buzzer on with no beeps left");

    a_all_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_op == OP_ALL_OFF |=>
            !r_buzzer && !r_green && !r_red && r_beeps_left == '0
            && !r_green_armed && !r_red_armed)
        else $error("all-off left something active");

    a_tick_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_op == OP_TICK && !i_cfg.block_ready |=>
            $stable(r_phase_rem) && $stable(r_green_rem) && $stable(r_red_rem)
            && $stable(r_beeps_left))
        else $error("tick changed counters while not ready");

    a_no_start_disabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_op == OP_BEEP && !i_cfg.beep_enable |=> $stable(r_beeps_left))
        else $error("beep started while disabled");

endmodule

`default_nettype wire

>>> src/buzzer_led_pattern_annunciator.sv
`timescale 1ns / 1ps
`default_nettype none

// Path: an accepted transfer is captured in the input register, then goes
//   through the state update that also holds the drive levels and sets the result valid.
// Throughput: one item per cycle while the result output is not stalled; the state update sets the pace.
// Reset (i_rst_n low, synchronous): pipeline empty, all counters and levels zero,
//   beep_enable = 1, block_ready = 0.
module buzzer_led_pattern_annunciator
    import ann_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,

    // item input channel
    input  wire logic             i_in_valid,
    output      logic             o_in_stall,
    input  wire logic [OP_W-1:0]  i_opcode,
    input  wire logic [DUR_W-1:0] i_duration_ms,
    input  wire logic             i_led_level,

    // result output channel
    output      logic             o_out_valid,
    input  wire logic             i_out_stall,
    output      logic             o_buzzer,
    output      logic             o_green_led,
    output      logic             o_red_led,

    // register port
    input  wire logic             psel,
    input  wire logic             penable,
    input  wire logic             pwrite,
    input  wire logic [2:0]       paddr,
    input  wire logic [31:0]      pwdata,
    output      logic [31:0]      prdata,
    output      logic             pready
);

    // Stage 1: input register.
    logic             r_in_valid;
    logic [OP_W-1:0]  r_op;
    logic [DUR_W-1:0] r_dur;
    logic             r_lvl;

    // Stage 2: result valid; the payload is the core's level state itself,
    // which only moves when a result is launched into this stage.
    logic             r_out_valid;

    logic    out_free;   // result stage can take a new result this cycle
    logic    fire;       // stage 1 item goes through the state update
    logic    in_xfer;    // input transfer
    t_cfg    cfg;
    t_levels levels;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_op  <= i_opcode;
            r_dur <= i_duration_ms;
            r_lvl <= i_led_level;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    ann_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ann_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_op     (r_op),
        .i_dur    (r_dur),
        .i_lvl    (r_lvl),
        .o_levels (levels)
    );

    assign o_out_valid = r_out_valid;
    assign o_buzzer    = levels.buzzer;
    assign o_green_led = levels.green;
    assign o_red_led   = levels.red;

    // The level state must not move under a stalled result.
    a_hold_levels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> $stable(levels))
        else $error("levels changed under stalled result");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid && i_out_stall)
        else $error("input stalled without a full pipe");

    a_fire_makes_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_out_valid)
        else $error("item updated state but no result shown");

endmodule

`default_nettype wire
